>>> rtl/core/unicode_to_utf16_transcoder_core_assert.svh
// Assertion macros shared by the transcoder core files.
`ifndef UNICODE_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UNICODE_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U16T_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("transcoder check failed");

// Next-cycle implication, disabled during reset.
`define U16T_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("transcoder check failed");

`endif

>>> rtl/core/u16t_pkg.sv
package u16t_pkg;

	// source_encoding codes
	localparam logic [2:0] ENC_UTF8    = 3'd0;
	localparam logic [2:0] ENC_U16AUTO = 3'd1;
	localparam logic [2:0] ENC_U16BE   = 3'd2;
	localparam logic [2:0] ENC_U16LE   = 3'd3;
	localparam logic [2:0] ENC_U32AUTO = 3'd4;
	localparam logic [2:0] ENC_U32BE   = 3'd5;
	localparam logic [2:0] ENC_U32LE   = 3'd6;
	localparam logic [2:0] ENC_NONE    = 3'd7;  // unknown: bytes are swallowed

	localparam logic [31:0] BOM_POINT = 32'h0000_FEFF;

	// up to two UTF-16 units produced by one source byte
	typedef struct packed {
		logic [1:0]  cnt;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        bad;
	} res_t;

endpackage

>>> rtl/core/u16t_decode.sv
`include "unicode_to_utf16_transcoder_core_assert.svh"

module u16t_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	input  logic            start_of_text,
	input  logic [2:0]      enc,
	output u16t_pkg::res_t  res
);
	import u16t_pkg::*;

	logic [23:0] held_q;
	logic [1:0]  hcnt_q;
	logic [30:0] acc_q;
	logic [2:0]  cont_q;
	logic        le_q;
	logic        await_q;

	logic [23:0] held_c, held_n;
	logic [1:0]  hcnt_c, hcnt_n;
	logic [30:0] acc_c, acc_n;
	logic [2:0]  cont_c, cont_n, cn;
	logic        le_c, le_n;
	logic        await_c, await_n;
	logic [5:0]  shamt;
	logic        size4, sub_auto, sub_le, le_use;
	logic [1:0]  lim;
	logic [31:0] word, swp, val;

	function automatic res_t point_res(input logic [31:0] cp);
		res_t r;
		r = '0;
		if (|cp[31:16]) begin
			r.cnt   = 2'd2;
			r.unit0 = {6'b110110, 10'(cp[19:10] - 10'd64)};
			r.unit1 = {6'b110111, cp[9:0]};
		end else begin
			r.cnt   = 2'd1;
			r.unit0 = cp[15:0];
		end
		return r;
	endfunction

	always_comb begin
		// new text drops any partial unit first
		held_c  = start_of_text ? 24'd0 : held_q;
		hcnt_c  = start_of_text ? 2'd0  : hcnt_q;
		acc_c   = start_of_text ? 31'd0 : acc_q;
		cont_c  = start_of_text ? 3'd0  : cont_q;
		le_c    = start_of_text ? 1'b0  : le_q;
		await_c = start_of_text ? 1'b1  : await_q;

		held_n  = held_c;
		hcnt_n  = hcnt_c;
		acc_n   = acc_c;
		cont_n  = cont_c;
		le_n    = le_c;
		await_n = await_c;
		res     = '0;

		cn       = cont_c - 3'd1;
		shamt    = 6'({cn, 2'b00}) + 6'({cn, 1'b0});
		size4    = enc[2];
		sub_auto = (enc == ENC_U16AUTO) || (enc == ENC_U32AUTO);
		sub_le   = (enc == ENC_U16LE) || (enc == ENC_U32LE);
		lim      = size4 ? 2'd3 : 2'd1;
		word     = size4 ? {held_c, data_byte} : {16'd0, held_c[7:0], data_byte};
		swp      = size4 ? {word[7:0], word[15:8], word[23:16], word[31:24]}
		                 : {16'd0, word[7:0], word[15:8]};
		le_use   = sub_le || (!sub_auto && 1'b0) || (sub_auto && le_c);
		val      = 32'd0;

		if (enc == ENC_UTF8) begin
			await_n = 1'b0;
			if (cont_c != 3'd0) begin
				cont_n = cn;
				acc_n  = acc_c | (31'({25'd0, data_byte[5:0]}) << shamt);
				if (cn == 3'd0)
					res = point_res({1'b0, acc_n});
			end else if (!data_byte[7]) begin
				res = point_res({24'd0, data_byte});
			end else if (data_byte[7:1] == 7'h7F) begin
				res.cnt = 2'd1;
				res.bad = 1'b1;
			end else begin
				priority casez (data_byte)
					8'b110?????: begin
						cont_n = 3'd1;
						acc_n  = {20'd0, data_byte[4:0], 6'd0};
					end
					8'b1110????: begin
						cont_n = 3'd2;
						acc_n  = {15'd0, data_byte[3:0], 12'd0};
					end
					8'b11110???: begin
						cont_n = 3'd3;
						acc_n  = {10'd0, data_byte[2:0], 18'd0};
					end
					8'b111110??: begin
						cont_n = 3'd4;
						acc_n  = {5'd0, data_byte[1:0], 24'd0};
					end
					8'b1111110?: begin
						cont_n = 3'd5;
						acc_n  = {data_byte[0], 30'd0};
					end
					default: begin
						// stray continuation byte in lead position
						res = point_res({26'd0, data_byte[5:0]});
					end
				endcase
			end
		end else if (enc != ENC_NONE) begin
			if (hcnt_c < lim) begin
				held_n = {held_c[15:0], data_byte};
				hcnt_n = hcnt_c + 2'd1;
			end else begin
				held_n = 24'd0;
				hcnt_n = 2'd0;
				if (await_c) begin
					await_n = 1'b0;
					if (sub_auto) begin
						le_use = (swp == BOM_POINT);
						le_n   = le_use;
					end
				end
				val = le_use ? swp : word;
				if (!(await_c && val == BOM_POINT)) begin
					if (size4) begin
						res = point_res(val);
					end else begin
						res.cnt   = 2'd1;
						res.unit0 = val[15:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			hcnt_q  <= '0;
			acc_q   <= '0;
			cont_q  <= '0;
			le_q    <= 1'b0;
			await_q <= 1'b1;
		end else if (fire) begin
			held_q  <= held_n;
			hcnt_q  <= hcnt_n;
			acc_q   <= acc_n;
			cont_q  <= cont_n;
			le_q    <= le_n;
			await_q <= await_n;
		end
	end

	`U16T_ASSERT_IMP(a_cont_range, clk, arst_n, 1'b1, cont_q <= 3'd5)

endmodule

>>> rtl/core/u16t_out.sv
`include "unicode_to_utf16_transcoder_core_assert.svh"

module u16t_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  u16t_pkg::res_t  res,
	output logic            free,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [15:0]     m_axis_tdata,
	output logic            m_axis_tlast,
	output logic            m_axis_tuser
);
	import u16t_pkg::*;

	logic [1:0]  n_q;
	logic [15:0] u0_q;
	logic [15:0] u1_q;
	logic        bad_q;

	// room for a new byte's units once the last pending beat leaves
	assign free          = (n_q == 2'd0) || (n_q == 2'd1 && m_axis_tready);
	assign m_axis_tvalid = (n_q != 2'd0);
	assign m_axis_tdata  = u0_q;
	assign m_axis_tlast  = (n_q == 2'd1);
	assign m_axis_tuser  = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= res.cnt;
		end else if (m_axis_tvalid && m_axis_tready) begin
			n_q <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			u0_q  <= res.unit0;
			u1_q  <= res.unit1;
			bad_q <= res.bad;
		end else if (m_axis_tvalid && m_axis_tready) begin
			u0_q <= u1_q;
		end
	end

	`U16T_ASSERT_IMP(a_bad_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata == 16'd0 && m_axis_tlast)
	`U16T_ASSERT_NXT(a_pair_tail, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tlast && !m_axis_tuser)

endmodule

>>> rtl/core/unicode_to_utf16_transcoder_core.sv
// Byte-serial transcoder from UTF-8, UTF-16 (auto/BE/LE) or UTF-32 (auto/BE/LE)
// text to UTF-16 code units. One source byte enters per beat and the core can
// take a new byte every cycle unless the output stalls; each byte yields zero,
// one or two output units. Output beats leave one per cycle while tready is
// high. A surrogate pair holds the next byte back until its second unit leaves;
// other bytes sustain one byte per cycle. Each beat passes the input register,
// then the result register. UTF-8 is not validated: stray continuation bytes
// give their low 6 bits, and lead bytes 0xFE/0xFF give a single beat with tuser
// set and data zero. A leading byte order mark is dropped in the UTF-16/UTF-32
// modes and picks byte order in the auto modes. Setting tuser on an input beat
// starts a new text and drops any partial unit. Encoding code 7 swallows bytes.
// Write cfg only while idle.
module unicode_to_utf16_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: source_encoding
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] start_of_text
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tlast,   // last_unit
	output logic        m_axis_tuser    // [0] bad_lead
);
	import u16t_pkg::*;

	logic [2:0] enc_q;

	// input register stage
	logic       s1_vld_q;
	logic [7:0] byte_s1;
	logic       sot_s1;

	logic       out_free;
	logic       process;
	res_t       res;

	// a byte is decoded when the result register can take its units
	assign process       = s1_vld_q && out_free;
	assign s_axis_tready = !s1_vld_q || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q <= ENC_UTF8;
		end else if (cfg_wr_en) begin
			enc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_vld_q <= 1'b1;
		end else if (process) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			sot_s1  <= s_axis_tuser;
		end
	end

	// decode state and unit build
	u16t_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (process),
		.data_byte     (byte_s1),
		.start_of_text (sot_s1),
		.enc           (enc_q),
		.res           (res)
	);

	// result register, serializes surrogate pairs
	u16t_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (process),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// a byte waiting on a full result register must hold
	`U16T_ASSERT_NXT(a_s1_hold, clk, arst_n, s1_vld_q && !s_axis_tready,
		s1_vld_q && $stable(byte_s1) && $stable(sot_s1))

endmodule

>>> tb/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u16t_pkg::*;

	localparam logic [7:0]  LEAD_FE      = 8'hFE;
	localparam logic [7:0]  LEAD_FF      = 8'hFF;
	localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
	localparam logic [15:0] SURR_HI_BASE = 16'hD800;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [31:0] UTF8_MAX     = 32'h7FFF_FFFF;

	localparam int DRAIN_CYCLES = 8;      // two-stage core, plus margin
	localparam int LONG_HOLD    = 48;     // long output hold-off, in cycles
	localparam int N_PHASES     = 16;
	localparam int PHASE_BYTES  = 26;
	localparam int TIMEOUT_NS   = 2_000_000;

	// One UTF-16 output beat as the core presents it.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last;
		logic        bad;
	} utf16_beat_t;

	localparam utf16_beat_t NO_BEAT = '0;

	// Directed stimulus row: either a source_encoding write or one input byte.
	// typed rows carry the expected beat written out by hand.
	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  enc;
		logic [7:0]  data;
		logic        sot;
		logic        typed;
		utf16_beat_t want;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sot;
	} src_byte_t;

	localparam int N_DIRECTED = 31;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// UTF-8: extremes, bad leads, stray continuations
		'{1'b1, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, ENC_UTF8, 8'h7F, 1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0}},
		'{1'b0, ENC_UTF8, 8'hFF, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{1'b0, ENC_UTF8, 8'hFE, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{1'b0, ENC_UTF8, 8'h80, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b1, '{16'h003F, 1'b1, 1'b0}},
		// six-byte sequence to 0x7FFFFFFF: surrogate halves wrap
		'{1'b0, ENC_UTF8, 8'hFD, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hBF, 1'b0, 1'b0, NO_BEAT},
		// partial sequence dropped by a new text
		'{1'b0, ENC_UTF8, 8'hC3, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h41, 1'b1, 1'b1, '{16'h0041, 1'b1, 1'b0}},
		// UTF-16 auto: LE mark picks little endian and is skipped
		'{1'b1, ENC_U16AUTO, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hFE, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h41, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		// UTF-32 LE: mark skipped, then a supplementary point
		'{1'b1, ENC_U32LE, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hFE, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'hF6, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h01, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h00, 1'b0, 1'b0, NO_BEAT},
		// unknown encoding: byte swallowed
		'{1'b1, ENC_NONE, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, ENC_UTF8, 8'h55, 1'b0, 1'b0, NO_BEAT}
	};

	// First eight random phases walk every encoding code once.
	localparam logic [2:0] PHASE_ORDER [8] = '{
		ENC_U16BE, ENC_UTF8, ENC_U32LE, ENC_U16LE,
		ENC_NONE, ENC_U32AUTO, ENC_U16AUTO, ENC_U32BE
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;       // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;     // [0] start_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;            // [15:0] code_unit
	logic        m_axis_tlast;            // last_unit
	logic        m_axis_tuser;            // [0] bad_lead

	// Expected output beats, oldest first.
	utf16_beat_t due_units [$];
	src_byte_t   text_q [$];
	int          mismatch_count = 0;
	bit          calm_tail = 1'b0;        // no idling on either side
	bit          out_hold_req = 1'b0;     // ask the receiver for a long hold-off

	// Transcoder state mirror, reset values.
	logic [2:0]  cur_enc = ENC_UTF8;
	logic [23:0] held_word = '0;
	int          held_n = 0;
	logic [31:0] utf8_acc = '0;
	int          utf8_cont = 0;
	bit          order_le = 1'b0;
	bit          first_unit_due = 1'b1;

	unicode_to_utf16_transcoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [31:0] swap_bytes(input logic [31:0] w, input bit is32);
		return is32 ? {w[7:0], w[15:8], w[23:16], w[31:24]} : {16'd0, w[7:0], w[15:8]};
	endfunction

	// Code point to one unit, or a surrogate pair with 10-bit masked halves.
	function automatic void point_to_units(input logic [31:0] cp, output int n,
			output utf16_beat_t r0, output utf16_beat_t r1);
		logic [31:0] v;
		v  = cp - SUPP_BASE;
		r1 = NO_BEAT;
		if (cp >= SUPP_BASE) begin
			r0 = '{code_unit: SURR_HI_BASE | {6'd0, v[19:10]}, last: 1'b0, bad: 1'b0};
			r1 = '{code_unit: SURR_LO_BASE | {6'd0, v[9:0]}, last: 1'b1, bad: 1'b0};
			n  = 2;
		end else begin
			r0 = '{code_unit: cp[15:0], last: 1'b1, bad: 1'b0};
			n  = 1;
		end
	endfunction

	// Advance the mirror by one accepted byte; returns 0..2 beats.
	function automatic void transcode_byte(input logic [7:0] b, input logic sot,
			output int n, output utf16_beat_t r0, output utf16_beat_t r1);
		logic [31:0] word;
		logic [31:0] val;
		int          ones;
		int          unit_bytes;
		bit          is32;
		bit          is_auto;
		bit          le;
		bit          skip;
		n    = 0;
		r0   = NO_BEAT;
		r1   = NO_BEAT;
		skip = 1'b0;
		if (sot) begin
			held_word      = '0;
			held_n         = 0;
			utf8_acc       = '0;
			utf8_cont      = 0;
			order_le       = 1'b0;
			first_unit_due = 1'b1;
		end
		if (cur_enc == ENC_UTF8) begin
			first_unit_due = 1'b0;
			if (utf8_cont != 0) begin
				// any byte counts as a continuation here
				utf8_cont--;
				utf8_acc = (utf8_acc | ({26'd0, b[5:0]} << (6 * utf8_cont))) & UTF8_MAX;
				if (utf8_cont == 0)
					point_to_units(utf8_acc, n, r0, r1);
			end else if (!b[7]) begin
				point_to_units({24'd0, b}, n, r0, r1);
			end else if (b == LEAD_FE || b == LEAD_FF) begin
				n  = 1;
				r0 = '{code_unit: 16'h0000, last: 1'b1, bad: 1'b1};
			end else begin
				ones = 0;
				while (ones < 8 && b[7 - ones])
					ones++;
				if (ones < 2) begin
					point_to_units({26'd0, b[5:0]}, n, r0, r1);
				end else begin
					utf8_cont = ones - 1;
					utf8_acc  = (({24'd0, b} & ((32'd1 << (7 - ones)) - 32'd1))
						<< (6 * (ones - 1))) & UTF8_MAX;
				end
			end
		end else if (cur_enc <= ENC_U32LE) begin
			is32       = cur_enc >= ENC_U32AUTO;
			unit_bytes = is32 ? 4 : 2;
			if (held_n < unit_bytes - 1) begin
				held_word = {held_word[15:0], b};
				held_n++;
			end else begin
				// unit built from the most recent bytes
				word = {held_word, b};
				if (!is32)
					word[31:16] = '0;
				held_word = '0;
				held_n    = 0;
				is_auto   = cur_enc == ENC_U16AUTO || cur_enc == ENC_U32AUTO;
				if (cur_enc == ENC_U16LE || cur_enc == ENC_U32LE)
					le = 1'b1;
				else if (is_auto)
					le = order_le;
				else
					le = 1'b0;
				if (first_unit_due) begin
					first_unit_due = 1'b0;
					if (is_auto) begin
						le       = swap_bytes(word, is32) == BOM_POINT;
						order_le = le;
					end
					val  = le ? swap_bytes(word, is32) : word;
					skip = val == BOM_POINT;
				end else begin
					val = le ? swap_bytes(word, is32) : word;
				end
				if (!skip) begin
					if (is32) begin
						point_to_units(val, n, r0, r1);
					end else begin
						n  = 1;
						r0 = '{code_unit: val[15:0], last: 1'b1, bad: 1'b0};
					end
				end
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Drive one byte, wait for its beat, then log what it should produce.
	task automatic send_byte(input logic [7:0] b, input logic sot, input logic typed,
			input utf16_beat_t want);
		int          n;
		utf16_beat_t r0;
		utf16_beat_t r1;
		if (!calm_tail && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= sot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		transcode_byte(b, sot, n, r0, r1);
		if (typed) begin
			due_units.push_back(want);
		end else begin
			if (n > 0)
				due_units.push_back(r0);
			if (n > 1)
				due_units.push_back(r1);
		end
	endtask

	// Register write only with the core drained, including bytes that
	// give no beat but may still sit in the pipe.
	task automatic write_encoding(input logic [2:0] enc);
		while (due_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= enc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_enc = enc;
	endtask

	task automatic add_word(input logic [31:0] w, input bit is32, input bit le);
		int nb;
		int k;
		nb = is32 ? 4 : 2;
		for (k = 0; k < nb; k++)
			text_q.push_back('{data: le ? w[8 * k +: 8] : w[8 * (nb - 1 - k) +: 8], sot: 1'b0});
	endtask

	// One text in the given encoding: optional mark, a few code points of
	// mixed size, sprinkled with stray bytes.
	task automatic build_text(input logic [2:0] enc);
		int          n_pts;
		int          k;
		int          j;
		int          nb;
		bit          is32;
		bit          le;
		bit          with_bom;
		logic [31:0] cp;
		logic [31:0] lead;
		text_q.delete();
		n_pts    = $urandom_range(2, 8);
		is32     = enc >= ENC_U32AUTO && enc <= ENC_U32LE;
		le       = enc == ENC_U16LE || enc == ENC_U32LE;
		with_bom = enc != ENC_UTF8 && enc != ENC_NONE && $urandom_range(0, 1);
		if (enc == ENC_U16AUTO || enc == ENC_U32AUTO)
			le = with_bom && $urandom_range(0, 1);
		if (with_bom)
			add_word(BOM_POINT, is32, le);
		for (k = 0; k < n_pts; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: cp = $urandom_range(0, 32'h7F);
				4:          cp = $urandom_range(32'h80, 32'h7FF);
				5, 6:       cp = $urandom_range(32'h800, 32'hFFFF);
				7, 8:       cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
				default:    cp = $urandom_range(32'h11_0000, UTF8_MAX);
			endcase
			if (is32 && $urandom_range(0, 7) == 0)
				cp = $urandom;
			if (enc == ENC_UTF8 || enc == ENC_NONE) begin
				nb = cp < 32'h80 ? 1 : cp < 32'h800 ? 2 : cp < 32'h1_0000 ? 3 :
					cp < 32'h20_0000 ? 4 : cp < 32'h400_0000 ? 5 : 6;
				if (nb == 1) begin
					text_q.push_back('{data: cp[7:0], sot: 1'b0});
				end else begin
					lead = (32'hFF << (8 - nb)) | (cp >> (6 * (nb - 1)));
					text_q.push_back('{data: lead[7:0], sot: 1'b0});
					for (j = nb - 2; j >= 0; j--)
						text_q.push_back('{data: 8'h80 | 8'((cp >> (6 * j)) & 32'h3F),
							sot: 1'b0});
				end
			end else begin
				add_word(cp, is32, le);
			end
			if ($urandom_range(0, 11) == 0)
				text_q.push_back('{data: 8'($urandom_range(0, 255)), sot: 1'b0});
		end
		// mostly a fresh text; sometimes it runs on from the last one
		text_q[0].sot = $urandom_range(0, 7) != 0;
	endtask

	// ---------------------------------------------------------------
	// Output side: ready generation and checking
	// ---------------------------------------------------------------

	// Short random stalls, plus a long hold-off on request so the core
	// backs up into its input.
	initial begin : out_ready_gen
		int gap;
		int held;
		gap = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_hold_req) begin
				out_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 10)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : out_check
		utf16_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_units.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat: unit %h last %b bad %b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser));
			end else begin
				want = due_units.pop_front();
				if (m_axis_tdata !== want.code_unit || m_axis_tlast !== want.last ||
						m_axis_tuser !== want.bad)
					flag_mismatch($sformatf(
						"beat mismatch: want unit %h last %b bad %b, got unit %h last %b bad %b",
						want.code_unit, want.last, want.bad,
						m_axis_tdata, m_axis_tlast, m_axis_tuser));
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin : main_seq
		int         i;
		int         k;
		int         phase;
		int         sent;
		logic [2:0] enc;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].is_cfg) begin
				s_axis_tvalid <= 1'b0;
				write_encoding(DIRECTED[i].enc);
			end else begin
				send_byte(DIRECTED[i].data, DIRECTED[i].sot, DIRECTED[i].typed,
					DIRECTED[i].want);
			end
		end

		// random phases: each one drains, picks an encoding, then streams
		// texts; the last two run with no idling at all
		for (phase = 0; phase < N_PHASES; phase++) begin
			enc = phase < 8 ? PHASE_ORDER[phase] : 3'($urandom_range(0, 7));
			s_axis_tvalid <= 1'b0;
			write_encoding(enc);
			calm_tail = phase >= N_PHASES - 2;
			if (phase == 2 || phase == 9)
				out_hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_text(enc);
				for (k = 0; k < text_q.size(); k++)
					send_byte(text_q[k].data, text_q[k].sot, 1'b0, NO_BEAT);
				sent += text_q.size();
			end
			// leave a partial unit behind for the next encoding now and then
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_BEAT);
		end

		s_axis_tvalid <= 1'b0;
		while (due_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && due_units.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/u16t_pkg.sv
rtl/core/u16t_decode.sv
rtl/core/u16t_out.sv
rtl/core/unicode_to_utf16_transcoder_core.sv
tb/tb.sv
